@@ sv/stc_pkg.sv @@
// Shared constants, codes and helper functions for the symbol transition count table.
`timescale 1ns / 1ps

package stc_pkg;

    localparam int SYMBOLS     = 32;
    localparam int COUNT_WIDTH = 16;

    // Fixed field widths of the transaction payloads
    localparam int FUNC_W  = 2;
    localparam int SYMF_W  = 5;
    localparam int CNTF_W  = 16;
    localparam int RATIO_W = 17;
    localparam int FRAC_W  = 16;

    localparam int SYM_W      = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int PAIR_DEPTH = SYMBOLS * SYMBOLS;
    localparam int PAIR_AW    = $clog2(PAIR_DEPTH);
    localparam int DIV_CNT_W  = $clog2(FRAC_W);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [RATIO_W-1:0]     RATIO_ONE = RATIO_W'(1 << FRAC_W);

    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY   = 2'd2;

    typedef logic [SYM_W-1:0]       sym_idx_t;
    typedef logic [PAIR_AW-1:0]     pair_addr_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;

    // Symbol field to store index (zero-extends or truncates as SYMBOLS needs)
    function automatic sym_idx_t sym_idx(input logic [SYMF_W-1:0] s);
        logic [SYM_W+SYMF_W-1:0] w;
        w = {{SYM_W{1'b0}}, s};
        return w[SYM_W-1:0];
    endfunction

    function automatic pair_addr_t pair_addr(input sym_idx_t early, input sym_idx_t later);
        return PAIR_AW'(int'(early) * SYMBOLS + int'(later));
    endfunction

    function automatic count_t sat_inc(input count_t v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    // Count to the 16-bit result field
    function automatic logic [CNTF_W-1:0] cnt_field(input count_t v);
        logic [COUNT_WIDTH+CNTF_W-1:0] w;
        w = {{CNTF_W{1'b0}}, v};
        return w[CNTF_W-1:0];
    endfunction

endpackage

@@ sv/stc_item_if.sv @@
// Input channel: func code and symbols, valid/ready handshake.
`timescale 1ns / 1ps

interface stc_item_if
    import stc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [SYMF_W-1:0] symbol;
    logic [SYMF_W-1:0] earlier_symbol;

    modport source (output valid, output func, output symbol, output earlier_symbol,
                    input ready);
    modport sink   (input valid, input func, input symbol, input earlier_symbol,
                    output ready);
endinterface

@@ sv/stc_result_if.sv @@
// Result channel: pair count, column total and ratio, valid/ready handshake.
`timescale 1ns / 1ps

interface stc_result_if
    import stc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CNTF_W-1:0]  pair_count;
    logic [CNTF_W-1:0]  column_total;
    logic [RATIO_W-1:0] ratio;

    modport source (output valid, output pair_count, output column_total, output ratio,
                    input ready);
    modport sink   (input valid, input pair_count, input column_total, input ratio,
                    output ready);
endinterface

@@ sv/symbol_transition_count_table_unit.sv @@
// Symbol transition count table: pair-count and column-total memories with query divider.
`timescale 1ns / 1ps

// Counts transitions between successive samples of an entropy source in a
// SYMBOLS x SYMBOLS pair-count memory plus a per-symbol column-total memory,
// both single-port synchronous RAMs with a registered read. A sample
// transaction is a memory read, then a saturating write-back; the
// next transaction is accepted right after the write, so back-to-back samples
// always see the updated entry. A query transaction is a read, operand
// setup, a restoring divider producing one quotient bit per cycle, and a
// result load; the divider is skipped when the ratio is zero or capped at 1.0.
// Queries wait for the result register to drain before loading it; samples
// and restarts are taken while a result is still pending. A restart, and the
// release of reset, start a clearing pass over all SYMBOLS*SYMBOLS pair entries
// (1024 at the default size) that zeroes both memories one entry per cycle; no
// transaction is accepted during the pass. Unused func codes and samples
// outside the symbol range are accepted and dropped.
module symbol_transition_count_table_unit
    import stc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    stc_item_if.sink     item,
    stc_result_if.source result
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_UPD   = 3'd2;
    localparam logic [2:0] ST_QRD   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_RES   = 3'd5;

    localparam pair_addr_t CLR_LAST = PAIR_AW'(PAIR_DEPTH - 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(FRAC_W - 1);

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    logic [2:0]  state_reg, state_next;
    pair_addr_t  clr_cnt_reg, clr_cnt_next;
    sym_idx_t    prev_reg;
    logic        have_prev_reg;
    logic        out_valid_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    // Payload / datapath registers
    pair_addr_t  upd_addr_reg;
    sym_idx_t    upd_sym_reg;
    logic        qry_ok_reg;
    count_t      c_reg, t_reg, rem_reg;
    logic [FRAC_W-1:0]  quo_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic [CNTF_W-1:0]  out_count_reg, out_total_reg;
    logic [RATIO_W-1:0] out_ratio_reg;

    // Memories
    count_t pair_mem [PAIR_DEPTH];
    count_t total_mem [SYMBOLS];
    count_t pair_rd_reg, total_rd_reg;

    logic       accept;
    logic       is_restart, is_sample, is_query;
    logic       sym_ok, early_ok;
    sym_idx_t   cur_idx, early_idx;
    pair_addr_t rd_pair_addr;
    logic       result_load;

    assign item.ready   = (state_reg == ST_IDLE);
    assign accept       = item.valid && item.ready;
    assign is_restart   = (item.func == FUNC_RESTART);
    assign is_sample    = (item.func == FUNC_SAMPLE);
    assign is_query     = (item.func == FUNC_QUERY);
    assign cur_idx      = sym_idx(item.symbol);
    assign early_idx    = sym_idx(item.earlier_symbol);
    assign sym_ok       = (int'(item.symbol) < SYMBOLS);
    assign early_ok     = (int'(item.earlier_symbol) < SYMBOLS);
    assign rd_pair_addr = is_query ? pair_addr(early_idx, cur_idx)
                                   : pair_addr(prev_reg, cur_idx);

    // Result register loads once it is empty or being drained this cycle
    assign result_load  = (state_reg == ST_RES) && (!out_valid_reg || result.ready);

    // ------------------------------------------------------------------
    // Query operand setup: zero for out-of-range pairs, special ratios
    // ------------------------------------------------------------------
    count_t q_count, q_total;
    logic   q_zero, q_cap;

    assign q_count = qry_ok_reg ? pair_rd_reg  : '0;
    assign q_total = qry_ok_reg ? total_rd_reg : '0;
    assign q_zero  = (q_count == '0) || (q_total == '0);
    assign q_cap   = (q_count >= q_total);

    // ------------------------------------------------------------------
    // Restoring divider step: one quotient bit per cycle, remainder < t
    // ------------------------------------------------------------------
    logic [COUNT_WIDTH:0] rem_sh, rem_diff;
    logic                 rem_ge;
    count_t               rem_new;
    logic [FRAC_W-1:0]    quo_new;

    assign rem_sh   = {rem_reg, 1'b0};
    assign rem_diff = rem_sh - {1'b0, t_reg};
    assign rem_ge   = (rem_sh >= {1'b0, t_reg});
    assign rem_new  = rem_ge ? rem_diff[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
    assign quo_new  = {quo_reg[FRAC_W-2:0], rem_ge};

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_LAST)
                begin
                    clr_cnt_next = '0;
                    state_next   = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_restart)
                    begin
                        clr_cnt_next = '0;
                        state_next   = ST_CLEAR;
                    end
                    else if (is_sample && sym_ok && have_prev_reg)
                        state_next = ST_UPD;
                    else if (is_query)
                        state_next = ST_QRD;
                end
            end
            ST_UPD:
                state_next = ST_IDLE;
            ST_QRD:
                state_next = (q_zero || q_cap) ? ST_RES : ST_DIV;
            ST_DIV:
            begin
                if (div_cnt_reg == DIV_LAST)
                    state_next = ST_RES;
            end
            ST_RES:
            begin
                if (result_load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_CLEAR;
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;

            if (accept && is_restart)
            begin
                prev_reg      <= '0;
                have_prev_reg <= 1'b0;
            end
            else if (accept && is_sample && sym_ok)
            begin
                prev_reg      <= cur_idx;
                have_prev_reg <= 1'b1;
            end

            if (state_reg == ST_DIV)
                div_cnt_reg <= div_cnt_reg + 1'b1;
            else
                div_cnt_reg <= '0;

            if (result_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            upd_addr_reg <= rd_pair_addr;
            upd_sym_reg  <= cur_idx;
            qry_ok_reg   <= sym_ok && early_ok;
        end

        if (state_reg == ST_QRD)
        begin
            c_reg   <= q_count;
            t_reg   <= q_total;
            rem_reg <= q_count;
            quo_reg <= '0;
            if (q_zero)
                ratio_reg <= '0;
            else if (q_cap)
                ratio_reg <= RATIO_ONE;
        end

        if (state_reg == ST_DIV)
        begin
            rem_reg <= rem_new;
            quo_reg <= quo_new;
            if (div_cnt_reg == DIV_LAST)
                ratio_reg <= {1'b0, quo_new};
        end

        if (result_load)
        begin
            out_count_reg <= cnt_field(c_reg);
            out_total_reg <= cnt_field(t_reg);
            out_ratio_reg <= ratio_reg;
        end
    end

    // ------------------------------------------------------------------
    // Pair-count memory: read on accept, write on update or clear sweep
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
            pair_mem[clr_cnt_reg] <= '0;
        else if (state_reg == ST_UPD)
            pair_mem[upd_addr_reg] <= sat_inc(pair_rd_reg);

        if (accept)
            pair_rd_reg <= pair_mem[rd_pair_addr];
    end

    // Column-total memory: cleared during the sweep while the clear counter is below SYMBOLS
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_CLEAR) && (int'(clr_cnt_reg) < SYMBOLS))
            total_mem[SYM_W'(clr_cnt_reg)] <= '0;
        else if (state_reg == ST_UPD)
            total_mem[upd_sym_reg] <= sat_inc(total_rd_reg);

        if (accept)
            total_rd_reg <= total_mem[cur_idx];
    end

    assign result.valid        = out_valid_reg;
    assign result.pair_count   = out_count_reg;
    assign result.column_total = out_total_reg;
    assign result.ratio        = out_ratio_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A sample with history always goes through the write-back cycle
    a_sample_upd: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_sample && sym_ok && have_prev_reg) |=> (state_reg == ST_UPD))
        else $error("sample with history skipped write-back");

    // A pending result is only dropped after the sink took it
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(result.valid) |-> $past(result.ready))
        else $error("result dropped without transaction");

    // Ratio never exceeds 1.0 in Q1.16
    a_ratio_cap: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.ratio <= RATIO_ONE))
        else $error("ratio above 1.0");

    // Divider remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < t_reg))
        else $error("divider remainder out of range");

endmodule
